// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the toroidal life generation core.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int SIZE_W   = 6;

  // command field codes
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // broadcast control from the command decode to every row cell
  typedef struct packed {
    logic              advance;
    logic              write;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              alive;
    logic [SIZE_W-1:0] nr;
    logic [SIZE_W-1:0] nc;
  } cell_ctrl_t;

endpackage

// ===== rtl/life_generation_step_core.sv =====
// ----------------------------------------------------------------------------
// life_generation_step_core
// Toroidal life grid with cell write, cell read and one-generation advance.
// ----------------------------------------------------------------------------
// A chain of row cells, one per grid row, computes a whole generation in the
// cycle the advance beat is accepted, and writes and reads act on the row
// registers directly. Results leave through an output register backed by one
// skid entry, so a new beat is taken every cycle while the result side keeps
// up, and one more while a result waits. Used rows and columns wrap as a
// torus; sizes written as 0 act as 1, above 32 as 32.
// ----------------------------------------------------------------------------
module life_generation_step_core
  import lgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // config write port
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata,
  // command beats
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,  // command[1:0], row[6:2], col[11:7], alive[12]
  // result beats
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata  // cell_alive[0], bad_coordinate[1]
);

  logic [SIZE_W-1:0]   nr_r, nr_nxt;
  logic [SIZE_W-1:0]   nc_r, nc_nxt;
  logic [SIZE_W-1:0]   nr_m1;
  logic [SIZE_W-1:0]   size_max;
  logic [SIZE_W-1:0]   clamped;

  logic [MAX_COLS-1:0] row_q [MAX_ROWS];
  logic [MAX_COLS-1:0] last_row;

  cmd_t                cmd;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic                in_alive;
  logic                accept;
  logic                coord_bad;
  logic                res_cell;
  logic                res_bad;
  cell_ctrl_t          ctrl;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_data_r, out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic [1:0]          skid_data_r, skid_data_nxt;
  logic                pop;

  // ---- configuration ----
  assign size_max = (cfg_index == CFG_ROWS) ? SIZE_W'(MAX_ROWS) : SIZE_W'(MAX_COLS);

  always_comb begin
    priority if (cfg_wdata == '0) begin
      clamped = SIZE_W'(1);
    end else if (cfg_wdata > size_max) begin
      clamped = size_max;
    end else begin
      clamped = cfg_wdata;
    end
  end

  always_comb begin
    nr_nxt = nr_r;
    nc_nxt = nc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: nr_nxt = clamped;
        CFG_COLS: nc_nxt = clamped;
        default:  ;
      endcase
    end
  end

  // ---- command decode ----
  assign cmd      = cmd_t'(in_tdata[1:0]);
  assign in_row   = in_tdata[6:2];
  assign in_col   = in_tdata[11:7];
  assign in_alive = in_tdata[12];
  assign accept   = in_tvalid && in_tready;

  assign coord_bad = ({1'b0, in_row} >= nr_r) || ({1'b0, in_col} >= nc_r);

  always_comb begin
    res_cell     = 1'b0;
    res_bad      = 1'b0;
    ctrl.advance = 1'b0;
    ctrl.write   = 1'b0;
    ctrl.row     = in_row;
    ctrl.col     = in_col;
    ctrl.alive   = in_alive;
    ctrl.nr      = nr_r;
    ctrl.nc      = nc_r;
    unique case (cmd)
      CMD_WRITE: begin
        res_bad    = coord_bad;
        ctrl.write = accept && !coord_bad;
      end
      CMD_READ: begin
        res_bad  = coord_bad;
        res_cell = !coord_bad && row_q[in_row][in_col];
      end
      CMD_ADVANCE: begin
        ctrl.advance = accept;
      end
      default: ;
    endcase
  end

  // ---- row cell chain ----
  assign nr_m1    = nr_r - SIZE_W'(1);
  assign last_row = row_q[nr_m1[ROW_W-1:0]];

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    localparam int RP = (r == 0) ? MAX_ROWS - 1 : r - 1;
    localparam int RN = (r == MAX_ROWS - 1) ? 0 : r + 1;

    lgs_row_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .my_idx      (ROW_W'(r)),
      .ctrl        (ctrl),
      .north_i     (row_q[RP]),
      .south_i     (row_q[RN]),
      .first_row_i (row_q[0]),
      .last_row_i  (last_row),
      .row_o       (row_q[r])
    );
  end

  // ---- result register with skid entry ----
  assign in_tready = !skid_valid_r;
  assign pop       = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {res_bad, res_cell};
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = {res_bad, res_cell};
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_r         <= SIZE_W'(30);
      nc_r         <= SIZE_W'(30);
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      nr_r         <= nr_nxt;
      nc_r         <= nc_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // ---- assertions ----
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a pending result");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("result flags both live and bad coordinate");

  a_sizes_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (nr_r != '0) && (nr_r <= SIZE_W'(MAX_ROWS)) &&
    (nc_r != '0) && (nc_r <= SIZE_W'(MAX_COLS)))
    else $error("used size outside 1..max");

  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.write |=> (row_q[$past(in_row)][$past(in_col)] == $past(in_alive)))
    else $error("cell write not stored");

endmodule

// ===== rtl/lgs_row_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_row_cell
// One grid row: holds its cells, applies cell writes, and computes the next
// generation from its own row and the rows handed over by its two neighbors in the chain.
// ----------------------------------------------------------------------------
module lgs_row_cell
  import lgs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ROW_W-1:0]    my_idx,
  input  cell_ctrl_t          ctrl,
  input  logic [MAX_COLS-1:0] north_i,
  input  logic [MAX_COLS-1:0] south_i,
  input  logic [MAX_COLS-1:0] first_row_i,
  input  logic [MAX_COLS-1:0] last_row_i,
  output logic [MAX_COLS-1:0] row_o
);

  logic [MAX_COLS-1:0] row_r;
  logic [MAX_COLS-1:0] row_nxt;
  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] below;
  logic [SIZE_W-1:0]   nr_m1;
  logic [SIZE_W-1:0]   nc_m1;
  logic [COL_W-1:0]    wrap_col;
  logic                row_used;
  logic                is_first;
  logic                is_last;
  logic                row_hit;

  assign nr_m1    = ctrl.nr - SIZE_W'(1);
  assign nc_m1    = ctrl.nc - SIZE_W'(1);
  assign wrap_col = nc_m1[COL_W-1:0];
  assign row_used = {1'b0, my_idx} < ctrl.nr;
  assign is_first = (my_idx == '0);
  assign is_last  = ({1'b0, my_idx} == nr_m1);
  assign row_hit  = ctrl.write && (ctrl.row == my_idx);

  // wrap at the used boundary, not at the physical one
  assign above = is_first ? last_row_i  : north_i;
  assign below = is_last  ? first_row_i : south_i;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    localparam int CP = (c == 0) ? MAX_COLS - 1 : c - 1;
    localparam int CN = (c == MAX_COLS - 1) ? 0 : c + 1;

    logic       col_used;
    logic       at_right;
    logic [2:0] lft;
    logic [2:0] rgt;
    logic [3:0] count;
    logic       born;

    assign col_used = (SIZE_W'(c) < ctrl.nc);
    assign at_right = (SIZE_W'(c) == nc_m1);
    assign lft = (c == 0) ? {above[wrap_col], row_r[wrap_col], below[wrap_col]}
                          : {above[CP], row_r[CP], below[CP]};
    assign rgt = at_right ? {above[0], row_r[0], below[0]}
                          : {above[CN], row_r[CN], below[CN]};
    assign count = 4'(lft[2]) + 4'(lft[1]) + 4'(lft[0])
                 + 4'(above[c]) + 4'(below[c])
                 + 4'(rgt[2]) + 4'(rgt[1]) + 4'(rgt[0]);
    assign born  = (count == 4'd3) || (row_r[c] && (count == 4'd2));

    always_comb begin
      row_nxt[c] = row_r[c];
      if (ctrl.advance && row_used && col_used) begin
        row_nxt[c] = born;
      end else if (row_hit && (ctrl.col == COL_W'(c))) begin
        row_nxt[c] = ctrl.alive;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_o = row_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives cell write, cell read and advance beats into the toroidal life core
// through several used sizes, predicts every result from a private copy of the
// grid, and checks each result beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import lgs_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES  = 10;
  localparam int         PHASE_BEATS = 110;
  localparam int         CALM_PHASE  = 4;
  localparam int         HOLD_PHASE  = 5;
  localparam int         HOLD_CYCLES = 300;

  typedef struct packed {
    logic             alive;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [1:0]       command;
  } life_cmd_t;

  typedef struct {
    bit cell_alive;
    bit bad_coordinate;
  } life_result_t;

  class life_grid_predictor;
    bit [MAX_COLS-1:0] grid [MAX_ROWS];
    logic [SIZE_W-1:0] rows_reg = 6'd30;
    logic [SIZE_W-1:0] cols_reg = 6'd30;
    life_result_t      expected_results [$];
    int                errors = 0;

    function int used_size(logic [SIZE_W-1:0] v, int max);
      if (v == 0) return 1;
      if (v > max) return max;
      return v;
    endfunction

    function int rows_used();
      return used_size(rows_reg, MAX_ROWS);
    endfunction

    function int cols_used();
      return used_size(cols_reg, MAX_COLS);
    endfunction

    function void set_size(logic idx, logic [SIZE_W-1:0] v);
      if (idx == CFG_ROWS) rows_reg = v;
      else cols_reg = v;
    endfunction

    // neighbor positions wrap modulo the used size, so tiny tori count a cell more than once
    function void step_generation();
      bit [MAX_COLS-1:0] nxt [MAX_ROWS];
      int nr, nc, n;
      nr = rows_used();
      nc = cols_used();
      nxt = grid;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = 0;
          for (int dr = 0; dr < 3; dr++)
            for (int dc = 0; dc < 3; dc++)
              if (!(dr == 1 && dc == 1))
                n += grid[(r + nr + dr - 1) % nr][(c + nc + dc - 1) % nc];
          nxt[r][c] = grid[r][c] ? (n == 2 || n == 3) : (n == 3);
        end
      end
      grid = nxt;
    endfunction

    function void note_command(life_cmd_t b);
      life_result_t res;
      res.cell_alive = 1'b0;
      res.bad_coordinate = 1'b0;
      if (b.command == CMD_WRITE || b.command == CMD_READ) begin
        if (b.row >= rows_used() || b.col >= cols_used()) begin
          res.bad_coordinate = 1'b1;
        end else if (b.command == CMD_WRITE) begin
          grid[b.row][b.col] = b.alive;
        end else begin
          res.cell_alive = grid[b.row][b.col];
        end
      end else if (b.command == CMD_ADVANCE) begin
        step_generation();
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] tdata);
      life_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat 0x%02h arrived with nothing expected", tdata);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (tdata[0] !== want.cell_alive) begin
        $error("cell_alive: expected %0d, got %0b", want.cell_alive, tdata[0]);
        errors++;
      end
      if (tdata[1] !== want.bad_coordinate) begin
        $error("bad_coordinate: expected %0d, got %0b", want.bad_coordinate, tdata[1]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [SIZE_W-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // command[1:0], row[6:2], col[11:7], alive[12]
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // cell_alive[0], bad_coordinate[1]

  life_grid_predictor sb = new();
  bit calm = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int rows_plan [NUM_PHASES] = '{1, 2, 0, 3, 32, 63, 33, 5, 17, 30};
  int cols_plan [NUM_PHASES] = '{1, 3, 2, 0, 32, 40, 63, 7, 32, 30};

  life_generation_step_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, or a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = calm || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_cmd(logic [1:0] command, int row, int col, bit alive);
    life_cmd_t b;
    b.command = command;
    b.row = row[ROW_W-1:0];
    b.col = col[COL_W-1:0];
    b.alive = alive;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b000, b};
    do @(posedge clk); while (!in_tready);
    sb.note_command(b);
  endtask

  // drop valid and hold until every result is back, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[SIZE_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_size(idx, value[SIZE_W-1:0]);
  endtask

  // mostly in-range writes and reads with some advances, plus out-of-range
  // coordinates and the unused command as noise
  task automatic send_random_cmd();
    int nr, nc, pick;
    nr = sb.rows_used();
    nc = sb.cols_used();
    pick = $urandom_range(99);
    if (pick < 40)
      send_cmd(CMD_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
               $urandom_range(99) < 60);
    else if (pick < 78)
      send_cmd(CMD_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
               $urandom_range(1));
    else if (pick < 88)
      send_cmd(CMD_ADVANCE, $urandom_range(31), $urandom_range(31), $urandom_range(1));
    else if (pick < 96)
      send_cmd($urandom_range(1) ? CMD_WRITE : CMD_READ, $urandom_range(31),
               $urandom_range(31), $urandom_range(1));
    else
      send_cmd(CMD_UNUSED, $urandom_range(31), $urandom_range(31), $urandom_range(1));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset sizes 30 by 30
    send_cmd(CMD_READ, 0, 0, 1'b0);
    send_cmd(CMD_WRITE, 0, 0, 1'b1);
    send_cmd(CMD_READ, 0, 0, 1'b0);
    send_cmd(CMD_WRITE, 29, 29, 1'b1);
    send_cmd(CMD_READ, 29, 29, 1'b1);
    send_cmd(CMD_WRITE, 30, 0, 1'b1);
    send_cmd(CMD_READ, 0, 30, 1'b0);
    send_cmd(CMD_WRITE, 31, 31, 1'b1);
    send_cmd(CMD_READ, 31, 31, 1'b1);
    send_cmd(CMD_UNUSED, 31, 31, 1'b1);
    // vertical blinker straddling the row wrap
    send_cmd(CMD_WRITE, 29, 15, 1'b1);
    send_cmd(CMD_WRITE, 0, 15, 1'b1);
    send_cmd(CMD_WRITE, 1, 15, 1'b1);
    send_cmd(CMD_ADVANCE, 0, 0, 1'b0);
    send_cmd(CMD_READ, 0, 14, 1'b0);
    send_cmd(CMD_READ, 0, 16, 1'b0);
    send_cmd(CMD_READ, 0, 15, 1'b0);
    send_cmd(CMD_READ, 29, 15, 1'b0);
    send_cmd(CMD_ADVANCE, 31, 31, 1'b1);
    send_cmd(CMD_READ, 29, 15, 1'b0);
    send_cmd(CMD_WRITE, 0, 15, 1'b0);
    send_cmd(CMD_READ, 0, 15, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      calm = (p == CALM_PHASE);
      write_cfg(CFG_ROWS, rows_plan[p]);
      write_cfg(CFG_COLS, cols_plan[p]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        send_random_cmd();
        // stall the result side while beats keep coming to back up the core
        if (p == HOLD_PHASE && k == 10) hold_left = HOLD_CYCLES;
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== life_generation_step_core.f =====
rtl/lgs_pkg.sv
rtl/lgs_row_cell.sv
rtl/life_generation_step_core.sv
dv/testbench.sv
